// File: sv/rk4s_pkg.sv
// Shared types, constants and helper functions of the RK4 vehicle dynamics step core.
package rk4s_pkg;

   localparam int FRAC_BITS_DEF    = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   localparam int NVARS      = 10;
   localparam int IDX_W      = 4;
   localparam int WORD_W     = 32;
   localparam int DT_W       = 17;
   localparam int ANG_BITS   = 30;
   localparam int ANG_W      = 34;
   localparam int OPND_W     = 36;
   localparam int PROD_W     = 72;
   localparam int ATAN_COUNT = 24;
   localparam int ATAN_IDX_W = 5;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [DT_W-1:0] STEP_TIME_RESET = 17'd3277;

   // Angles in Q30 radians.
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint TWO_PI_Q30  = 64'sd6746518853;
   localparam longint GAIN_Q30    = 64'sd652032874;

   localparam logic OPC_LOAD = 1'b0;
   localparam logic OPC_STEP = 1'b1;

   localparam logic [REG_IDX_W-1:0] REG_STEP_TIME = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_DAMPING   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_STIFFNESS = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ACCEL_CPL = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_TURN_CPL  = 3'd4;

   localparam logic [IDX_W-1:0] V_X        = 4'd0;
   localparam logic [IDX_W-1:0] V_Y        = 4'd1;
   localparam logic [IDX_W-1:0] V_YAW      = 4'd2;
   localparam logic [IDX_W-1:0] V_SPEED    = 4'd3;
   localparam logic [IDX_W-1:0] V_YAW_RATE = 4'd4;
   localparam logic [IDX_W-1:0] V_PROGRESS = 4'd5;
   localparam logic [IDX_W-1:0] V_EX       = 4'd6;
   localparam logic [IDX_W-1:0] V_EXD      = 4'd7;
   localparam logic [IDX_W-1:0] V_EY       = 4'd8;
   localparam logic [IDX_W-1:0] V_EYD      = 4'd9;

   typedef enum logic [3:0] {
      OP_VCOS, OP_VSIN, OP_DEXD, OP_KEX, OP_AA, OP_DEYD, OP_KEY, OP_TV, OP_TVW
   } der_op_type;

   typedef enum logic [3:0] {
      SQ_IDLE, SQ_TRIG_GO, SQ_TRIG_WAIT, SQ_DER_ISSUE, SQ_DER_TAKE, SQ_ACCUM,
      SQ_STG_ISSUE, SQ_STG_TAKE, SQ_FIN_ISSUE, SQ_FIN_TAKE, SQ_DIV_ISSUE,
      SQ_DIV_TAKE, SQ_RESULT
   } seq_state_type;

   typedef enum logic [2:0] {
      TR_IDLE, TR_REDUCE, TR_FOLD, TR_ROTATE, TR_DONE
   } trig_state_type;

   typedef struct packed {
      logic [DT_W-1:0]          step_time;
      logic signed [WORD_W-1:0] damping;
      logic signed [WORD_W-1:0] stiffness;
      logic signed [WORD_W-1:0] accel_cpl;
      logic signed [WORD_W-1:0] turn_cpl;
   } cfg_type;

   typedef struct packed {
      logic                     start;
      logic signed [WORD_W-1:0] yaw;
   } trig_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [ANG_W-1:0] cos_v;
      logic signed [ANG_W-1:0] sin_v;
   } trig_rsp_type;

   function automatic logic signed [ANG_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] i);
      logic signed [ANG_W-1:0] v;
      unique case (i)
         5'd0:  v = 34'sd843314857;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043837;
         5'd3:  v = 34'sd133525159;
         5'd4:  v = 34'sd67021687;
         5'd5:  v = 34'sd33543516;
         5'd6:  v = 34'sd16775851;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194283;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048576;
         5'd11: v = 34'sd524288;
         5'd12: v = 34'sd262144;
         5'd13: v = 34'sd131072;
         5'd14: v = 34'sd65536;
         5'd15: v = 34'sd32768;
         5'd16: v = 34'sd16384;
         5'd17: v = 34'sd8192;
         5'd18: v = 34'sd4096;
         5'd19: v = 34'sd2048;
         5'd20: v = 34'sd1024;
         5'd21: v = 34'sd512;
         5'd22: v = 34'sd256;
         5'd23: v = 34'sd128;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'(64'sd2147483647);
      lo = PROD_W'(-64'sd2147483648);
      if (v > hi) return 32'sh7fffffff;
      if (v < lo) return 32'sh80000000;
      return WORD_W'(v);
   endfunction

endpackage

// File: sv/rk4_vehicle_dynamics_step_core.sv
// Top level of the RK4 vehicle dynamics step core: sequencer, state and result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  req     | in        | req_tvalid/req_tready  | tuser opcode, tdata load value/controls
//  rsp     | out       | rsp_tvalid/rsp_tready  | tdata ten new state words
//  csr     | in/out    | psel/penable, pready=1 | five configuration registers
//
// A load item gives no result. A step item keeps the core busy after it is accepted; its
// run is paced by the single shared multiplier, issued and then read back once per
// product, and by the iterative trig unit. Reset clears the state words and loads the
// registers. A finished result waits in its own register, so a following load is taken
// while it is stalled; the next step result waits until the earlier one has gone.
module rk4_vehicle_dynamics_step_core #(
   parameter int FRAC_BITS    = rk4s_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = rk4s_pkg::CORDIC_STEPS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata, from bit 0: var_index[3:0], var_value[35:4], accel[67:36],
   // yaw_accel[99:68], path_speed[131:100], zero fill [135:132]
   input  logic [135:0]                    req_tdata,
   // tuser, from bit 0: opcode
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata, from bit 0 in 32-bit words: pos_x, pos_y, heading, speed, yaw_rate,
   // progress, dist_long, dist_long_rate, dist_lat, dist_lat_rate
   output logic [319:0]                    rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rk4s_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rk4s_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rk4s_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import rk4s_pkg::*;

   localparam int NQ_W      = 35;
   localparam int DIV_SHIFT = 36;
   localparam logic [IDX_W-1:0] LAST_VAR = IDX_W'(NVARS - 1);

   // Rounding offsets for the various product scalings.
   localparam logic signed [PROD_W-1:0] HALF_30  = PROD_W'(1) <<< (ANG_BITS - 1);
   localparam logic signed [PROD_W-1:0] HALF_F   = PROD_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [PROD_W-1:0] HALF_F1  = PROD_W'(1) <<< FRAC_BITS;
   localparam logic signed [PROD_W-1:0] FIN_BIAS = PROD_W'(3) <<< FRAC_BITS;
   // The final increment is divided by three through a reciprocal. Clamping the
   // dividend to three times 2^32 keeps every saturating result as it was.
   localparam logic signed [PROD_W-1:0] CLAMP    = PROD_W'(64'sd12884901888);
   localparam logic signed [PROD_W-1:0] INC_BIAS = PROD_W'(64'sd4294967296);
   localparam logic signed [OPND_W-1:0] RECIP_3  = 36'sd22906492245;

   cfg_type      cfg;
   trig_req_type trig_req;
   trig_rsp_type trig_rsp;

   seq_state_type seq_ff, seq_in;
   der_op_type    op_ff, op_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [1:0]       n_ff, n_in;

   logic signed [WORD_W-1:0] state_ff [NVARS];
   logic signed [WORD_W-1:0] state_in [NVARS];
   logic signed [WORD_W-1:0] cur_ff   [NVARS];
   logic signed [WORD_W-1:0] cur_in   [NVARS];
   logic signed [WORD_W-1:0] k_ff     [NVARS];
   logic signed [WORD_W-1:0] k_in     [NVARS];
   logic signed [OPND_W-1:0] ksum_ff  [NVARS];
   logic signed [OPND_W-1:0] ksum_in  [NVARS];
   logic signed [WORD_W-1:0] out_ff   [NVARS];
   logic signed [WORD_W-1:0] out_in   [NVARS];

   logic signed [WORD_W-1:0] acc_ff, acc_in, ya_ff, ya_in, ps_ff, ps_in;
   logic signed [WORD_W-1:0] ta_ff, ta_in, tb_ff, tb_in, tc_ff, tc_in;
   logic signed [ANG_W-1:0]  cos_ff, cos_in, sin_ff, sin_in;
   logic [NQ_W-1:0]          nq_ff, nq_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic signed [OPND_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;

   logic                     req_fire;
   logic                     rsp_free;
   logic [IDX_W-1:0]         ld_idx;
   logic signed [WORD_W-1:0] ld_val;

   logic signed [PROD_W-1:0] rnd30_w, rndf_w, rndf1_w, fin_w, qcl_w;
   logic signed [WORD_W-1:0] rndf_sat;
   logic signed [PROD_W-1:0] der_sum_w, stg_w, upd_w, inc_w;
   logic [NQ_W-1:0]          qe_w;
   logic [NQ_W+1:0]          rem_w;
   logic [NQ_W:0]            qt_w;

   rk4s_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rk4s_trig #(
      .FRAC_BITS    (FRAC_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_trig (
      .clock (clock),
      .reset (reset),
      .req   (trig_req),
      .rsp   (trig_rsp)
   );

   rk4s_mul u_mul (
      .clock  (clock),
      .opnd_a (mul_a),
      .opnd_b (mul_b),
      .prod   (prod)
   );

   assign req_tready = (seq_ff == SQ_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign ld_idx     = req_tdata[3:0];
   assign ld_val     = $signed(req_tdata[35:4]);

   assign trig_req.start = (seq_ff == SQ_TRIG_GO);
   assign trig_req.yaw   = cur_ff[V_YAW];

   // Next state of the sequencer.
   always_comb begin
      seq_in = seq_ff;
      unique case (seq_ff)
         SQ_IDLE:      if (req_fire && req_tuser[0] == OPC_STEP) seq_in = SQ_TRIG_GO;
         SQ_TRIG_GO:   seq_in = SQ_TRIG_WAIT;
         SQ_TRIG_WAIT: if (trig_rsp.done) seq_in = SQ_DER_ISSUE;
         SQ_DER_ISSUE: seq_in = SQ_DER_TAKE;
         SQ_DER_TAKE:  seq_in = (op_ff == OP_TVW) ? SQ_ACCUM : SQ_DER_ISSUE;
         SQ_ACCUM:     seq_in = (n_ff == 2'd3) ? SQ_FIN_ISSUE : SQ_STG_ISSUE;
         SQ_STG_ISSUE: seq_in = SQ_STG_TAKE;
         SQ_STG_TAKE:  seq_in = (j_ff == LAST_VAR) ? SQ_TRIG_GO : SQ_STG_ISSUE;
         SQ_FIN_ISSUE: seq_in = SQ_FIN_TAKE;
         SQ_FIN_TAKE:  seq_in = SQ_DIV_ISSUE;
         SQ_DIV_ISSUE: seq_in = SQ_DIV_TAKE;
         SQ_DIV_TAKE:  seq_in = (j_ff == LAST_VAR) ? SQ_RESULT : SQ_FIN_ISSUE;
         SQ_RESULT:    if (rsp_free) seq_in = SQ_IDLE;
         default:      seq_in = SQ_IDLE;
      endcase
   end

   // Operands for the shared multiplier, chosen by the step under way.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (seq_ff)
         SQ_DER_ISSUE: begin
            unique case (op_ff)
               OP_VCOS: begin mul_a = OPND_W'(cur_ff[V_SPEED]);  mul_b = OPND_W'(cos_ff);          end
               OP_VSIN: begin mul_a = OPND_W'(cur_ff[V_SPEED]);  mul_b = OPND_W'(sin_ff);          end
               OP_DEXD: begin mul_a = OPND_W'(cfg.damping);      mul_b = OPND_W'(cur_ff[V_EXD]);   end
               OP_KEX:  begin mul_a = OPND_W'(cfg.stiffness);    mul_b = OPND_W'(cur_ff[V_EX]);    end
               OP_AA:   begin mul_a = OPND_W'(cfg.accel_cpl);    mul_b = OPND_W'(acc_ff);          end
               OP_DEYD: begin mul_a = OPND_W'(cfg.damping);      mul_b = OPND_W'(cur_ff[V_EYD]);   end
               OP_KEY:  begin mul_a = OPND_W'(cfg.stiffness);    mul_b = OPND_W'(cur_ff[V_EY]);    end
               OP_TV:   begin mul_a = OPND_W'(cfg.turn_cpl);     mul_b = OPND_W'(cur_ff[V_SPEED]); end
               OP_TVW:  begin mul_a = OPND_W'(tc_ff);            mul_b = OPND_W'(cur_ff[V_YAW_RATE]); end
               default: begin end
            endcase
         end
         SQ_STG_ISSUE: begin
            mul_a = OPND_W'(k_ff[j_ff]);
            mul_b = $signed({{(OPND_W-DT_W){1'b0}}, cfg.step_time});
         end
         SQ_FIN_ISSUE: begin
            mul_a = ksum_ff[j_ff];
            mul_b = $signed({{(OPND_W-DT_W){1'b0}}, cfg.step_time});
         end
         SQ_DIV_ISSUE: begin
            mul_a = $signed({1'b0, nq_ff});
            mul_b = RECIP_3;
         end
         default: begin end
      endcase
   end

   // Datapath: what each step does with the product and the stored words.
   always_comb begin
      rnd30_w  = (prod + HALF_30) >>> ANG_BITS;
      rndf_w   = (prod + HALF_F) >>> FRAC_BITS;
      rndf1_w  = (prod + HALF_F1) >>> (FRAC_BITS + 1);
      fin_w    = (prod + FIN_BIAS) >>> (FRAC_BITS + 1);
      rndf_sat = sat32(rndf_w);
      der_sum_w = -PROD_W'(ta_ff) - PROD_W'(tb_ff) - PROD_W'(rndf_sat);
      stg_w = PROD_W'(state_ff[j_ff]) + ((n_ff < 2'd2) ? rndf1_w : rndf_w);
      if (fin_w > CLAMP) begin
         qcl_w = CLAMP;
      end else if (fin_w < -CLAMP) begin
         qcl_w = -CLAMP;
      end else begin
         qcl_w = fin_w;
      end
      qe_w  = prod[DIV_SHIFT+NQ_W-1:DIV_SHIFT];
      rem_w = (NQ_W+2)'(nq_ff) - ((NQ_W+2)'(qe_w) << 1) - (NQ_W+2)'(qe_w);
      qt_w  = (NQ_W+1)'(qe_w) + (NQ_W+1)'(rem_w >= (NQ_W+2)'(3));
      inc_w = PROD_W'($signed({1'b0, qt_w})) - INC_BIAS;
      upd_w = PROD_W'(state_ff[j_ff]) + inc_w;

      state_in = state_ff;
      cur_in   = cur_ff;
      k_in     = k_ff;
      ksum_in  = ksum_ff;
      out_in   = out_ff;
      op_in    = op_ff;
      j_in     = j_ff;
      n_in     = n_ff;
      acc_in   = acc_ff;
      ya_in    = ya_ff;
      ps_in    = ps_ff;
      ta_in    = ta_ff;
      tb_in    = tb_ff;
      tc_in    = tc_ff;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      nq_in    = nq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (seq_ff)
         SQ_IDLE: begin
            if (req_fire) begin
               if (req_tuser[0] == OPC_LOAD) begin
                  // An index past the last state word is dropped.
                  if (ld_idx < IDX_W'(NVARS)) state_in[ld_idx] = ld_val;
               end else begin
                  acc_in = $signed(req_tdata[67:36]);
                  ya_in  = $signed(req_tdata[99:68]);
                  ps_in  = $signed(req_tdata[131:100]);
                  cur_in = state_ff;
                  n_in   = 2'd0;
               end
            end
         end
         SQ_TRIG_GO: begin
            // The derivative words that are copies need no multiplier.
            k_in[V_YAW]      = cur_ff[V_YAW_RATE];
            k_in[V_SPEED]    = acc_ff;
            k_in[V_YAW_RATE] = ya_ff;
            k_in[V_PROGRESS] = ps_ff;
            k_in[V_EX]       = cur_ff[V_EXD];
            k_in[V_EY]       = cur_ff[V_EYD];
         end
         SQ_TRIG_WAIT: begin
            if (trig_rsp.done) begin
               cos_in = trig_rsp.cos_v;
               sin_in = trig_rsp.sin_v;
               op_in  = OP_VCOS;
            end
         end
         SQ_DER_TAKE: begin
            unique case (op_ff)
               OP_VCOS: k_in[V_X] = sat32(rnd30_w);
               OP_VSIN: k_in[V_Y] = sat32(rnd30_w);
               OP_DEXD: ta_in = rndf_sat;
               OP_KEX:  tb_in = rndf_sat;
               OP_AA:   k_in[V_EXD] = sat32(der_sum_w);
               OP_DEYD: ta_in = rndf_sat;
               OP_KEY:  tb_in = rndf_sat;
               OP_TV:   tc_in = rndf_sat;
               OP_TVW:  k_in[V_EYD] = sat32(der_sum_w);
               default: begin end
            endcase
            if (op_ff != OP_TVW) op_in = der_op_type'(op_ff + 1'b1);
         end
         SQ_ACCUM: begin
            // Weights one, two, two, one over the four derivative evaluations.
            for (int i = 0; i < NVARS; i++) begin
               unique case (n_ff)
                  2'd0:       ksum_in[i] = OPND_W'(k_ff[i]);
                  2'd1, 2'd2: ksum_in[i] = ksum_ff[i] + (OPND_W'(k_ff[i]) <<< 1);
                  2'd3:       ksum_in[i] = ksum_ff[i] + OPND_W'(k_ff[i]);
                  default:    ksum_in[i] = ksum_ff[i];
               endcase
            end
            j_in = '0;
         end
         SQ_STG_TAKE: begin
            cur_in[j_ff] = sat32(stg_w);
            if (j_ff == LAST_VAR) begin
               n_in = n_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         SQ_FIN_TAKE: begin
            nq_in = NQ_W'(qcl_w + CLAMP);
         end
         SQ_DIV_TAKE: begin
            state_in[j_ff] = sat32(upd_w);
            if (j_ff != LAST_VAR) j_in = j_ff + 1'b1;
         end
         SQ_RESULT: begin
            if (rsp_free) begin
               out_in       = state_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SQ_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NVARS; i++) state_ff[i] <= '0;
      end else begin
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
      cur_ff  <= cur_in;
      k_ff    <= k_in;
      ksum_ff <= ksum_in;
      out_ff  <= out_in;
      op_ff   <= op_in;
      j_ff    <= j_in;
      n_ff    <= n_in;
      acc_ff  <= acc_in;
      ya_ff   <= ya_in;
      ps_ff   <= ps_in;
      ta_ff   <= ta_in;
      tb_ff   <= tb_in;
      tc_ff   <= tc_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
      nq_ff   <= nq_in;
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      for (int i = 0; i < NVARS; i++) rsp_tdata[i*WORD_W +: WORD_W] = out_ff[i];
   end

   // The trig unit only finishes while the sequencer is waiting for it.
   a_trig_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      trig_rsp.done |-> seq_ff == SQ_TRIG_WAIT)
      else $error("trig unit finished outside its wait step");

   // A new result only ever comes from the result step.
   a_result_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(seq_ff) == SQ_RESULT)
      else $error("result raised outside the result step");

   // The word counter stays on a real state word while it indexes the arrays.
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SQ_STG_TAKE || seq_ff == SQ_DIV_TAKE) |-> j_ff <= LAST_VAR)
      else $error("state word index out of range");

endmodule

// File: sv/rk4s_mul.sv
// Shared signed multiplier with a registered product.
module rk4s_mul (
   input  logic                                clock,
   input  logic signed [rk4s_pkg::OPND_W-1:0]  opnd_a,
   input  logic signed [rk4s_pkg::OPND_W-1:0]  opnd_b,
   output logic signed [rk4s_pkg::PROD_W-1:0]  prod
);
   import rk4s_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = PROD_W'(opnd_a) * PROD_W'(opnd_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// File: sv/rk4s_trig.sv
// Iterative angle reduction and CORDIC sine and cosine unit.
module rk4s_trig #(
   parameter int FRAC_BITS    = rk4s_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STEPS = rk4s_pkg::CORDIC_STEPS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rk4s_pkg::trig_req_type req,
   output rk4s_pkg::trig_rsp_type rsp
);
   import rk4s_pkg::*;

   // The angle is offset by 2*pi*2^K so that it is never negative, then reduced
   // by one conditional subtraction of 2*pi*2^i per cycle, i from K down to 0.
   localparam int K  = ANG_BITS - 1 - FRAC_BITS;
   localparam int RW = K + 35;

   localparam logic signed [RW-1:0] PI_R      = RW'(PI_Q30);
   localparam logic signed [RW-1:0] HALF_PI_R = RW'(HALF_PI_Q30);
   localparam logic signed [RW-1:0] TWO_PI_R  = RW'(TWO_PI_Q30);
   localparam logic signed [RW-1:0] MOD_TOP   = TWO_PI_R <<< K;
   localparam logic signed [ANG_W-1:0] GAIN_A = ANG_W'(GAIN_Q30);

   trig_state_type state_ff, state_in;
   logic signed [RW-1:0]    r_ff, r_in;
   logic signed [RW-1:0]    m_ff, m_in;
   logic [ATAN_IDX_W-1:0]   cnt_ff, cnt_in;
   logic signed [ANG_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic                    flip_ff, flip_in;

   logic signed [RW-1:0]    r_half;
   logic signed [RW-1:0]    r_fold;
   logic                    fold_flip;
   logic signed [ANG_W-1:0] xs, ys;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TR_IDLE:   if (req.start) state_in = TR_REDUCE;
         TR_REDUCE: if (cnt_ff == '0) state_in = TR_FOLD;
         TR_FOLD:   state_in = TR_ROTATE;
         TR_ROTATE: if (cnt_ff == ATAN_IDX_W'(CORDIC_STEPS - 1)) state_in = TR_DONE;
         TR_DONE:   state_in = TR_IDLE;
         default:   state_in = TR_IDLE;
      endcase
   end

   always_comb begin
      r_half    = (r_ff > PI_R) ? r_ff - TWO_PI_R : r_ff;
      fold_flip = 1'b0;
      if (r_half > HALF_PI_R) begin
         r_fold    = PI_R - r_half;
         fold_flip = 1'b1;
      end else if (r_half < -HALF_PI_R) begin
         r_fold    = -PI_R - r_half;
         fold_flip = 1'b1;
      end else begin
         r_fold = r_half;
      end
      xs = x_ff >>> cnt_ff;
      ys = y_ff >>> cnt_ff;

      r_in    = r_ff;
      m_in    = m_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      unique case (state_ff)
         TR_IDLE: begin
            if (req.start) begin
               r_in   = (RW'(req.yaw) <<< (ANG_BITS - FRAC_BITS)) + MOD_TOP;
               m_in   = MOD_TOP;
               cnt_in = ATAN_IDX_W'(K);
            end
         end
         TR_REDUCE: begin
            if (r_ff >= m_ff) r_in = r_ff - m_ff;
            m_in = m_ff >>> 1;
            if (cnt_ff != '0) cnt_in = cnt_ff - 1'b1;
         end
         TR_FOLD: begin
            z_in    = ANG_W'(r_fold);
            flip_in = fold_flip;
            x_in    = GAIN_A;
            y_in    = '0;
            cnt_in  = '0;
         end
         TR_ROTATE: begin
            if (z_ff >= 0) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_q30(cnt_ff);
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_q30(cnt_ff);
            end
            cnt_in = cnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      r_ff    <= r_in;
      m_ff    <= m_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   assign rsp.done  = (state_ff == TR_DONE);
   assign rsp.cos_v = flip_ff ? -x_ff : x_ff;
   assign rsp.sin_v = y_ff;

endmodule

// File: sv/rk4s_csr.sv
// Configuration register block with an APB-style access port.
module rk4s_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rk4s_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [rk4s_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [rk4s_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready,
   output rk4s_pkg::cfg_type                    cfg
);
   import rk4s_pkg::*;

   cfg_type               cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_STEP_TIME: cfg_in.step_time = csr_pwdata[DT_W-1:0];
            REG_DAMPING:   cfg_in.damping   = $signed(csr_pwdata);
            REG_STIFFNESS: cfg_in.stiffness = $signed(csr_pwdata);
            REG_ACCEL_CPL: cfg_in.accel_cpl = $signed(csr_pwdata);
            REG_TURN_CPL:  cfg_in.turn_cpl  = $signed(csr_pwdata);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_STEP_TIME: csr_prdata = CSR_DATA_W'(cfg_ff.step_time);
         REG_DAMPING:   csr_prdata = cfg_ff.damping;
         REG_STIFFNESS: csr_prdata = cfg_ff.stiffness;
         REG_ACCEL_CPL: csr_prdata = cfg_ff.accel_cpl;
         REG_TURN_CPL:  csr_prdata = cfg_ff.turn_cpl;
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_time <= STEP_TIME_RESET;
         cfg_ff.damping   <= '0;
         cfg_ff.stiffness <= '0;
         cfg_ff.accel_cpl <= '0;
         cfg_ff.turn_cpl  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
